// File: rtl/core/ffc_pkg.sv
// Package: command codes, error codes and field constants for the float format converter.
package ffc_pkg;
    typedef enum logic [2:0] {
        CMD_MBF1_TO_IEEE1 = 3'd0,
        CMD_MBF2_TO_IEEE2 = 3'd1,
        CMD_IEEE1_TO_MBF1 = 3'd2,
        CMD_IEEE2_TO_MBF1_UNUSED = 3'd6,
        CMD_IEEE2_TO_MBF2 = 3'd3,
        CMD_DBL_TO_INT16  = 3'd4,
        CMD_DBL_TO_SINGLE = 3'd5
    } t_cmd;

    typedef enum logic {
        ERR_NONE     = 1'b0,
        ERR_OVERFLOW = 1'b1
    } t_err;

    localparam int unsigned DATA_W = 64;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        t_err              error_code;
    } t_res;
endpackage

// File: rtl/core/ffc_datapath.sv
// Datapath: combinational conversion of one command and operand to one result.
module ffc_datapath (
    input  logic [2:0]                  i_cmd,
    input  logic [ffc_pkg::DATA_W-1:0]  i_operand,
    output ffc_pkg::t_res               o_res
);
    import ffc_pkg::*;

    logic [63:0] op;
    logic [7:0]  e1;
    logic [7:0]  e2;
    logic [63:0] res_m1;
    logic [63:0] res_m2;
    logic [8:0]  em1;
    logic [63:0] res_i1;
    logic [11:0] ed;
    logic [63:0] res_i2;
    logic        sgn;
    logic [10:0] ex;
    logic [51:0] man;
    logic [52:0] sig;
    // int16 path
    logic [5:0]  sh_i;
    logic [52:0] q_i;
    logic [52:0] rem_i;
    logic [52:0] half_i;
    logic        up_i;
    logic [16:0] qr_i;
    logic [15:0] neg_i;
    logic [63:0] res_int;
    logic        err_int;
    // single path
    logic [24:0] q_s;
    logic [28:0] rem_s;
    logic        up_s;
    logic [24:0] r_s;
    logic [8:0]  fe_s;
    logic [23:0] rn;
    logic [63:0] res_s;
    logic        err_s;
    logic [6:0]  sh_d;
    logic [52:0] q_d;
    logic [52:0] rem_d;
    logic [52:0] half_d;
    logic        up_d;
    logic [23:0] r_d;
    logic [63:0] res;
    logic        err;

    always_comb begin
        op  = i_operand;
        sgn = op[63];
        ex  = op[62:52];
        man = op[51:0];
        sig = {1'b1, man};

        e1 = op[31:24];
        res_m1 = (e1 <= 8'd2) ? 64'd0
               : {32'd0, op[23], e1 - 8'd2, op[22:0]};

        e2 = op[63:56];
        res_m2 = (e2 == 8'd0) ? 64'd0
               : {op[55], 11'(e2) + 11'd894, op[54:3]};

        em1 = {1'b0, op[30:23]} + 9'd2;
        if (op[30:0] == 31'd0) begin
            res_i1 = 64'd0;
        end else begin
            res_i1 = {32'd0, (em1 > 9'd255) ? 8'hFF : em1[7:0], op[31], op[22:0]};
        end

        ed = {1'b0, ex} - 12'd894;
        if (op[62:0] == 63'd0 || ex <= 11'd894) begin
            res_i2 = 64'd0;
        end else begin
            res_i2 = {(ex > 11'd1149) ? 8'hFF : ed[7:0], sgn, man, 3'b000};
        end

        // double -> int16
        sh_i   = 6'(11'd1075 - ((ex >= 11'd1022 && ex < 11'd1038) ? ex : 11'd1075));
        q_i    = sig >> sh_i;
        rem_i  = sig & ((53'd1 << sh_i) - 53'd1);
        half_i = 53'd1 << (sh_i - 6'd1);
        up_i   = (rem_i > half_i) || (rem_i == half_i && q_i[0]);
        qr_i   = q_i[16:0] + {16'd0, up_i};
        neg_i  = 16'd0 - qr_i[15:0];
        res_int = 64'd0;
        err_int = 1'b0;
        if (ex == 11'h7FF) begin
            err_int = 1'b1;
        end else if (ex < 11'd1022) begin
            res_int = 64'd0;
        end else if (ex >= 11'd1038) begin
            if (sgn && ex == 11'd1038 && man == 52'd0) begin
                res_int = 64'h8000;
            end else begin
                err_int = 1'b1;
            end
        end else if (!sgn && q_i >= 53'd32767 && rem_i != 53'd0) begin
            err_int = 1'b1;
        end else begin
            res_int = {48'd0, sgn ? neg_i : qr_i[15:0]};
        end

        // double -> single, normal result
        q_s   = {1'b0, sig[52:29]};
        rem_s = sig[28:0];
        up_s  = (rem_s > 29'h1000_0000) || (rem_s == 29'h1000_0000 && q_s[0]);
        r_s   = q_s + {24'd0, up_s};
        fe_s  = 9'(ex - 11'd896);
        rn    = r_s[24] ? r_s[24:1] : r_s[23:0];
        if (r_s[24]) begin
            fe_s = fe_s + 9'd1;
        end
        // subnormal result: shift = 30 - fe = 926 - ex
        sh_d   = 7'((ex >= 11'd863) ? 11'd926 - ex : 11'd63);
        q_d    = (sh_d >= 7'd53) ? 53'd0 : sig >> sh_d[5:0];
        rem_d  = sig & ((53'd1 << sh_d[5:0]) - 53'd1);
        half_d = 53'd1 << (sh_d[5:0] - 6'd1);
        if (sh_d >= 7'd54) begin
            rem_d  = sig;
            half_d = 53'd0;
        end
        up_d = (sh_d == 7'd53) ? (sig > {1'b1, 52'd0})
             : (sh_d > 7'd53) ? 1'b0
             : ((rem_d > half_d) || (rem_d == half_d && q_d[0]));
        r_d  = q_d[23:0] + {23'd0, up_d};
        err_s = 1'b0;
        if (ex == 11'h7FF) begin
            res_s = (man == 52'd0) ? {32'd0, sgn, 31'h7F800000}
                  : {32'd0, sgn, 8'hFF, 1'b1, man[50:29]};
        end else if (ex == 11'd0 || ex < 11'd863) begin
            res_s = {32'd0, sgn, 31'd0};
        end else if (ex >= 11'd897) begin
            if (ex >= 11'd1151 || (ex == 11'd1150 && r_s[24])) begin
                err_s = 1'b1;
                res_s = 64'd0;
            end else begin
                res_s = {32'd0, sgn, fe_s[7:0], rn[22:0]};
            end
        end else begin
            res_s = {32'd0, sgn, 7'd0, r_d};
        end

        res = 64'd0;
        err = 1'b0;
        unique case (i_cmd)
            CMD_MBF1_TO_IEEE1: res = res_m1;
            CMD_MBF2_TO_IEEE2: res = res_m2;
            CMD_IEEE1_TO_MBF1: res = res_i1;
            CMD_IEEE2_TO_MBF2: res = res_i2;
            CMD_DBL_TO_INT16: begin
                res = res_int;
                err = err_int;
            end
            CMD_DBL_TO_SINGLE: begin
                res = res_s;
                err = err_s;
            end
            default: res = 64'd0;
        endcase
        o_res.result     = err ? 64'd0 : res;
        o_res.error_code = err ? ERR_OVERFLOW : ERR_NONE;
    end
endmodule

// File: rtl/core/float_format_converter_core.sv
// Top level: float format converter with input and result registers.
// Path from start to o_valid: input register, then result register.
// Throughput: one transfer per cycle; busy is always low.
// Results are shown for one cycle on o_valid; the receiver cannot stall.
// Reset: i_rst_n synchronous active low clears the valid flags.
// No state besides the two pipeline stages.
module float_format_converter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_cmd,
    input  logic [ffc_pkg::DATA_W-1:0]  i_operand,
    output logic                        o_valid,
    output logic [ffc_pkg::DATA_W-1:0]  o_result,
    output logic                        o_error_code
);
    import ffc_pkg::*;

    logic              r_in_vld;
    logic [2:0]        r_cmd;
    logic [DATA_W-1:0] r_operand;
    logic              r_out_vld;
    t_res              r_res;
    t_res              n_res;

    assign busy = 1'b0;

    ffc_datapath u_dp (
        .i_cmd     (r_cmd),
        .i_operand (r_operand),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= start;
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= i_cmd;
        r_operand <= i_operand;
        r_res     <= n_res;
    end

    assign o_valid      = r_out_vld;
    assign o_result     = r_res.result;
    assign o_error_code = r_res.error_code;

`ifndef NO_ASSERTIONS
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start ##2 1'b1 |-> o_valid)
        else $error("result missing two cycles after transfer");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code |-> o_result == '0)
        else $error("error result not zero");
    a_noerr_mbf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_cmd != CMD_DBL_TO_INT16 && r_cmd != CMD_DBL_TO_SINGLE
        |=> !o_error_code)
        else $error("error on a command that cannot fail");
`endif
endmodule
